// ===== src/abas_pkg.sv =====
`timescale 1ns / 1ps
package abas_pkg;
    localparam int CoordW = 16;
    localparam int MagW   = 17;
    localparam int MidW   = 7;
    localparam int TermW  = 18;
    localparam logic [15:0] ErrInit = 16'd32767;

    typedef logic [7:0] rom_t [256];
    localparam rom_t SineRom = '{
        8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,8'd152,8'd155,8'd158,8'd162,
        8'd165,8'd167,8'd170,8'd173,8'd176,8'd179,8'd182,8'd185,8'd188,8'd190,8'd193,8'd196,
        8'd198,8'd201,8'd203,8'd206,8'd208,8'd211,8'd213,8'd215,8'd218,8'd220,8'd222,8'd224,
        8'd226,8'd228,8'd230,8'd232,8'd234,8'd235,8'd237,8'd238,8'd240,8'd241,8'd243,8'd244,
        8'd245,8'd246,8'd248,8'd249,8'd250,8'd250,8'd251,8'd252,8'd253,8'd253,8'd254,8'd254,
        8'd254,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd254,8'd253,
        8'd253,8'd252,8'd251,8'd250,8'd250,8'd249,8'd248,8'd246,8'd245,8'd244,8'd243,8'd241,
        8'd240,8'd238,8'd237,8'd235,8'd234,8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,8'd220,
        8'd218,8'd215,8'd213,8'd211,8'd208,8'd206,8'd203,8'd201,8'd198,8'd196,8'd193,8'd190,
        8'd188,8'd185,8'd182,8'd179,8'd176,8'd173,8'd170,8'd167,8'd165,8'd162,8'd158,8'd155,
        8'd152,8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,8'd131,8'd128,8'd124,8'd121,8'd118,
        8'd115,8'd112,8'd109,8'd106,8'd103,8'd100,8'd97,8'd93,8'd90,8'd88,8'd85,8'd82,
        8'd79,8'd76,8'd73,8'd70,8'd67,8'd65,8'd62,8'd59,8'd57,8'd54,8'd52,8'd49,
        8'd47,8'd44,8'd42,8'd40,8'd37,8'd35,8'd33,8'd31,8'd29,8'd27,8'd25,8'd23,
        8'd21,8'd20,8'd18,8'd17,8'd15,8'd14,8'd12,8'd11,8'd10,8'd9,8'd7,8'd6,
        8'd5,8'd5,8'd4,8'd3,8'd2,8'd2,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd2,8'd2,8'd3,8'd4,8'd5,
        8'd5,8'd6,8'd7,8'd9,8'd10,8'd11,8'd12,8'd14,8'd15,8'd17,8'd18,8'd20,
        8'd21,8'd23,8'd25,8'd27,8'd29,8'd31,8'd33,8'd35,8'd37,8'd40,8'd42,8'd44,
        8'd47,8'd49,8'd52,8'd54,8'd57,8'd59,8'd62,8'd65,8'd67,8'd70,8'd73,8'd76,
        8'd79,8'd82,8'd85,8'd88,8'd90,8'd93,8'd97,8'd100,8'd103,8'd106,8'd109,8'd112,
        8'd115,8'd118,8'd121,8'd124
    };

    typedef struct packed {
        logic [MagW-1:0] ax;
        logic [MagW-1:0] ay;
        logic            xneg;
        logic            yneg;
        logic            special;
        logic [7:0]      special_angle;
        logic [MidW-1:0] lo;
        logic [MidW-1:0] hi;
        logic [MidW-1:0] best;
        logic [15:0]     best_err;
    } srch_t;

    function automatic logic signed [8:0] rom_signed(input logic [7:0] idx);
        return $signed({1'b0, SineRom[idx]}) - 9'sd128;
    endfunction
endpackage

// ===== src/atan2_binary_angle_search_top.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata bits
// s_      | in  | [15:0] coord_y, [31:16] coord_x
// m_      | out | [7:0] angle
// One pair per cycle while the pipeline is not stalled; two stages per bisection step.
// The whole pipeline advances together; when the output register is full and
// m_tready is low, every stage holds.
// Reset clears valid bits only.
module atan2_binary_angle_search_top
    import abas_pkg::*;
#(
    parameter int SEARCH_STEPS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // coord_y, coord_x
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // angle
);
    logic  en;
    logic  v_reg [SEARCH_STEPS+1];
    srch_t d_reg [SEARCH_STEPS+1];
    logic  out_valid_reg;
    logic [7:0] out_angle_reg, angle_next;
    logic signed [CoordW-1:0] cy, cx;
    srch_t first;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_angle_reg;
    assign cy = s_tdata[15:0];
    assign cx = s_tdata[31:16];

    always_comb begin
        first.ax = cx[15] ? MagW'(-$signed({cx[15], cx})) : MagW'(cx);
        first.ay = cy[15] ? MagW'(-$signed({cy[15], cy})) : MagW'(cy);
        first.xneg = cx[15];
        first.yneg = cy[15];
        first.special = (cx == 0) || (cy == 0);
        if (cx == 0 && cy == 0)     first.special_angle = 8'd0;
        else if (cx == 0)           first.special_angle = cy[15] ? 8'd192 : 8'd64;
        else if (cx[15])            first.special_angle = 8'd128;
        else                        first.special_angle = 8'd0;
        first.lo = '0;
        first.hi = MidW'(64);
        first.best = '0;
        first.best_err = ErrInit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg[0] <= 1'b0;
        else if (en)  v_reg[0] <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) d_reg[0] <= first;
    end

    for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_step
        abas_step u_step (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(v_reg[i]), .in_data(d_reg[i]),
            .out_valid_reg(v_reg[i+1]), .out_data_reg(d_reg[i+1])
        );
    end

    always_comb begin
        srch_t f;
        f = d_reg[SEARCH_STEPS];
        if (f.special)              angle_next = f.special_angle;
        else if (!f.xneg && !f.yneg) angle_next = 8'(f.best);
        else if (f.xneg && !f.yneg)  angle_next = 8'd128 - 8'(f.best);
        else if (f.xneg && f.yneg)   angle_next = 8'd128 + 8'(f.best);
        else                         angle_next = 8'd0 - 8'(f.best);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (en)  out_valid_reg <= v_reg[SEARCH_STEPS];
    end
    always_ff @(posedge aclk) begin
        if (en) out_angle_reg <= angle_next;
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("stalled with empty output");
    a_move: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg[0]))
        else $error("first stage moved during stall");
endmodule

// ===== src/abas_step.sv =====
`timescale 1ns / 1ps
module abas_step
    import abas_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  srch_t in_data,
    output logic  out_valid_reg,
    output srch_t out_data_reg
);
    // stage A: products; stage B: compare and bisect
    logic            a_valid_reg;
    srch_t           a_data_reg;
    logic [MidW-1:0] a_mid_reg;
    logic signed [TermW-1:0] a_lhs_reg, a_rhs_reg;

    logic [MidW-1:0] mid;
    logic signed [MagW+9:0] p_l, p_r, q_l, q_r;
    logic signed [TermW:0] diff;
    logic [TermW:0] err;
    srch_t nxt;

    always_comb begin
        mid = MidW'((8'(in_data.lo) + 8'(in_data.hi)) >> 1);
        p_l = $signed({1'b0, in_data.ay}) * rom_signed(8'(mid) + 8'd64);
        p_r = $signed({1'b0, in_data.ax}) * rom_signed(8'(mid));
        q_l = p_l / 128;
        q_r = p_r / 128;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= in_valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_data_reg   <= in_data;
            a_mid_reg    <= mid;
            a_lhs_reg    <= TermW'(q_l);
            a_rhs_reg    <= TermW'(q_r);
            out_data_reg <= nxt;
        end
    end

    always_comb begin
        nxt  = a_data_reg;
        diff = (TermW+1)'(a_lhs_reg) - (TermW+1)'(a_rhs_reg);
        err  = diff[TermW] ? (TermW+1)'(-diff) : (TermW+1)'(diff);
        if (err < (TermW+1)'(a_data_reg.best_err)) begin
            nxt.best_err = 16'(err);
            nxt.best     = a_mid_reg;
        end
        if (a_lhs_reg < a_rhs_reg) begin
            nxt.hi = a_mid_reg;
        end else begin
            nxt.lo = a_mid_reg + 1'b1;
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
class angle_scoreboard;
    logic [7:0] pending_angles[$];
    int         mismatches;

    static function automatic int rom_term(int idx);
        return int'(abas_pkg::SineRom[idx & 255]) - 128;
    endfunction

    static function automatic logic [7:0] predict_angle(logic signed [15:0] y,
                                                        logic signed [15:0] x);
        longint ax, ay, lhs, rhs, diff, best_diff;
        int     lo, hi, mid, best;
        if (x == 0 && y == 0) return 8'd0;
        if (x == 0) return (y > 0) ? 8'd64 : 8'd192;
        if (y == 0) return (x > 0) ? 8'd0 : 8'd128;
        ax = (x > 0) ? longint'(x) : -longint'(x);
        ay = (y > 0) ? longint'(y) : -longint'(y);
        lo = 0;
        hi = 64;
        best = 0;
        best_diff = 32767;
        for (int k = 0; k < 8; k++) begin
            mid = (lo + hi) / 2;
            lhs = (ay * rom_term(mid + 64)) / 128;
            rhs = (ax * rom_term(mid)) / 128;
            diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
            if (diff < best_diff) begin
                best_diff = diff;
                best = mid;
            end
            if (lhs < rhs) hi = mid;
            else lo = mid + 1;
        end
        if (x > 0 && y > 0) return 8'(best);
        if (x < 0 && y > 0) return 8'(128 - best);
        if (x < 0 && y < 0) return 8'(128 + best);
        return 8'(256 - best);
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    function void note_pair(logic [31:0] data);
        pending_angles.push_back(predict_angle(data[15:0], data[31:16]));
    endfunction

    task check_angle(logic [7:0] got);
        logic [7:0] exp_angle;
        if (pending_angles.size() == 0) begin
            report($sformatf("unexpected angle %0d", got));
        end else begin
            exp_angle = pending_angles.pop_front();
            if (got !== exp_angle) begin
                report($sformatf("angle %0d, expected %0d", got, exp_angle));
            end
        end
    endtask
endclass

module testbench;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    int send_idle;
    int recv_idle;
    angle_scoreboard sb;

    atan2_binary_angle_search_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_angle(m_tdata);
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_pair(logic [15:0] y, logic [15:0] x);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {x, y};
        do @(posedge aclk); while (!s_tready);
        sb.note_pair({x, y});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_angles.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(16)) - 8);
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edge_vals[8];
        sb = new();
        edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100,
                      16'hff00, 16'h5555};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        send_idle = 21;
        recv_idle = 64;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                send_pair(edge_vals[i], edge_vals[j]);
        drain_results();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 21 : (phase == 1) ? 64 : 0;
            recv_idle = (phase == 0) ? 64 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < 560; n++) send_pair(pick_coord(), pick_coord());
            if (phase == 0) drain_results();
        end
        drain_results();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_angles.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== atan2_binary_angle_search_top.f =====
src/abas_pkg.sv
src/abas_step.sv
src/atan2_binary_angle_search_top.sv
dv/testbench.sv
